FILE: hw/rtl/lhods_pkg.sv
// Shared types, codes and constants of the lift homing and omni drive sequencer.
// Used by every module under hw/rtl; depends on nothing.
package lhods_pkg;

	// Lift count, job lengths, step counter width and queue size.
	localparam int NUM_LIFTS     = 4;
	localparam int HOMING_STEPS  = 4;
	localparam int DRIVE_STEPS   = 8;
	localparam int STEP_W        = 3;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QUEUE_PTR_W   = 1;

	// Input operation codes.
	localparam logic [1:0] OP_STATE    = 2'd0;
	localparam logic [1:0] OP_FEEDBACK = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	// Reported system states of interest.
	localparam logic [1:0] ST_EMERGENCY = 2'd0;
	localparam logic [1:0] ST_DRIVE     = 2'd2;

	// Homing phases.
	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_HOMING = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_HOME_RPM  = 2'd0;
	localparam logic [1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_MAX_RPM   = 2'd2;
	localparam logic [1:0] CFG_LIFT_STEP = 2'd3;

	// Configuration reset values.
	localparam logic signed [22:0] HOME_RPM_RST  = -23'sd76800;
	localparam logic [14:0]        THRESHOLD_RST = 15'd3000;
	localparam logic [14:0]        MAX_RPM_RST   = 15'd5000;
	localparam logic [14:0]        LIFT_STEP_RST = 15'd1280;

	// Job kinds held in the queue.
	localparam logic JOB_HOMING = 1'b0;
	localparam logic JOB_DRIVE  = 1'b1;

	// Kinds of one back-end step.
	localparam logic [1:0] STEP_HOME  = 2'd0;
	localparam logic [1:0] STEP_WHEEL = 2'd1;
	localparam logic [1:0] STEP_LIFT  = 2'd2;

	// Control modes and motor numbering.
	localparam logic       CTRL_SPEED     = 1'b0;
	localparam logic       CTRL_POSITION  = 1'b1;
	localparam logic [3:0] WHEEL_ID_BASE  = 4'd1;
	localparam logic [3:0] LIFT_ID_BASE   = 4'd5;
	localparam logic [3:0] LAST_MOTOR_NUM = 4'd8;

	// Rounding constants: Q1.15 times rpm into Q.8 is a shift by 7, lift step by 15.
	localparam int WHEEL_SHIFT = 7;
	localparam int LIFT_SHIFT  = 15;
	localparam logic signed [33:0] WHEEL_HALF = 34'sd64;
	localparam logic signed [33:0] LIFT_HALF  = 34'sd16384;

	typedef struct packed {
		logic [1:0]         operation;
		logic [1:0]         report_state;
		logic [1:0]         lift_index;
		logic signed [15:0] lift_current;
		logic signed [31:0] lift_angle;
		logic signed [15:0] joy_forward;
		logic signed [15:0] joy_sideways;
		logic signed [15:0] joy_turn;
		logic signed [15:0] joy_lift;
		logic               joy_present;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         motor_num;
		logic               control_mode;
		logic signed [31:0] setpoint;
		logic               last_command;
	} out_item_t;

	typedef struct packed {
		logic signed [22:0] home_rpm;
		logic [14:0]        current_threshold;
		logic [14:0]        max_wheel_rpm;
		logic [14:0]        lift_step;
	} cfg_t;

	// One classified control tick waiting for the back end.
	typedef struct packed {
		logic                           kind;
		logic [NUM_LIFTS-1:0]           hit;
		logic                           all_hit;
		logic [NUM_LIFTS-1:0][31:0]     angle;
		logic signed [15:0]             fwd;
		logic signed [15:0]             side;
		logic signed [15:0]             turn;
		logic signed [15:0]             lift;
	} job_t;

	// One command travelling down the back-end pipeline.
	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         idx;
		logic [3:0]         motor_num;
		logic               mode;
		logic               last;
		logic               hit;
		logic               clear_goals;
		logic signed [31:0] angle;
		logic signed [31:0] value;
	} step_t;

endpackage

FILE: hw/rtl/lhods_front.sv
// Front end: accepts input beats, keeps system state, homing phase and lift feedback,
// and turns live control ticks into jobs for the queue. Depends on lhods_pkg.
module lhods_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lhods_pkg::in_item_t in_data,
	input  lhods_pkg::cfg_t     cfg,
	input  logic                q_full,
	output logic                q_push,
	output lhods_pkg::job_t     q_job
);

	logic [1:0] last_state_q;
	logic [1:0] phase_q;
	logic [lhods_pkg::NUM_LIFTS-1:0][15:0] cur_q;
	logic [lhods_pkg::NUM_LIFTS-1:0][31:0] ang_q;

	logic                            accept;
	logic                            tick_live;
	logic [lhods_pkg::NUM_LIFTS-1:0] hit;
	logic [16:0]                     mag [lhods_pkg::NUM_LIFTS];

	// A beat is taken whenever the queue has room for a job.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// End stop detection: absolute current against the threshold, per lift.
	always_comb begin
		for (int i = 0; i < lhods_pkg::NUM_LIFTS; i++) begin
			if (cur_q[i][15]) begin
				mag[i] = 17'd0 - {1'b1, cur_q[i]};
			end else begin
				mag[i] = {1'b0, cur_q[i]};
			end
			hit[i] = mag[i] > {2'b00, cfg.current_threshold};
		end
	end

	// Ticks only count while the last report was drive.
	assign tick_live = accept && (in_data.operation == lhods_pkg::OP_TICK) &&
		(last_state_q == lhods_pkg::ST_DRIVE);

	always_comb begin
		q_push = tick_live && ((phase_q == lhods_pkg::PH_HOMING) ||
			((phase_q == lhods_pkg::PH_DONE) && in_data.joy_present));
		q_job.kind    = (phase_q == lhods_pkg::PH_HOMING) ? lhods_pkg::JOB_HOMING :
			lhods_pkg::JOB_DRIVE;
		q_job.hit     = hit;
		q_job.all_hit = &hit;
		q_job.angle   = ang_q;
		q_job.fwd     = in_data.joy_forward;
		q_job.side    = in_data.joy_sideways;
		q_job.turn    = in_data.joy_turn;
		q_job.lift    = in_data.joy_lift;
	end

	// State reports, feedback capture and the homing phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_state_q <= lhods_pkg::ST_EMERGENCY;
			phase_q      <= lhods_pkg::PH_IDLE;
			cur_q        <= '0;
			ang_q        <= '0;
		end else if (accept) begin
			unique case (in_data.operation)
				lhods_pkg::OP_STATE: begin
					if ((last_state_q != lhods_pkg::ST_DRIVE) &&
						(in_data.report_state == lhods_pkg::ST_DRIVE) &&
						((phase_q == lhods_pkg::PH_IDLE) ||
						(phase_q == lhods_pkg::PH_DONE))) begin
						phase_q <= lhods_pkg::PH_HOMING;
					end
					if (in_data.report_state == lhods_pkg::ST_EMERGENCY) begin
						phase_q <= lhods_pkg::PH_IDLE;
					end
					last_state_q <= in_data.report_state;
				end
				lhods_pkg::OP_FEEDBACK: begin
					cur_q[in_data.lift_index] <= in_data.lift_current;
					ang_q[in_data.lift_index] <= in_data.lift_angle;
				end
				lhods_pkg::OP_TICK: begin
					if (tick_live && (phase_q == lhods_pkg::PH_HOMING) && (&hit)) begin
						phase_q <= lhods_pkg::PH_DONE;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/lhods_queue.sv
// Short job queue between the front and back ends, so that each side can stall alone.
// Depends on lhods_pkg for the job type and depth.
module lhods_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lhods_pkg::job_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            valid,
	output lhods_pkg::job_t head
);

	logic [lhods_pkg::QUEUE_PTR_W-1:0] wr_q;
	logic [lhods_pkg::QUEUE_PTR_W-1:0] rd_q;
	logic [lhods_pkg::QUEUE_PTR_W:0]   count_q;
	lhods_pkg::job_t                   slot_q [lhods_pkg::QUEUE_DEPTH];

	assign full  = count_q == (lhods_pkg::QUEUE_PTR_W+1)'(lhods_pkg::QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign head  = slot_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == lhods_pkg::QUEUE_PTR_W'(lhods_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == lhods_pkg::QUEUE_PTR_W'(lhods_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into a full queue");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("job popped from an empty queue");

endmodule

FILE: hw/rtl/lhods_back.sv
// Back end: steps through each job one command per cycle unless the output stalls,
// in a four-stage pipeline (operand select, multiply, round, lift goal update) into
// the output register. Owns the lift origins and goals. Depends on lhods_pkg.
module lhods_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lhods_pkg::cfg_t      cfg,
	input  logic                 q_valid,
	input  lhods_pkg::job_t      q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lhods_pkg::out_item_t out_data
);

	// Sequencer over the steps of the current job.
	logic                          en;
	logic                          busy_q;
	logic [lhods_pkg::STEP_W-1:0]  step_q;
	lhods_pkg::job_t               job_q;
	logic                          last_step;
	logic                          take;

	// Pipeline stages.
	logic                 v_s1, v_s2, v_s3, v_s4;
	lhods_pkg::step_t     st_d, st_s1, st_s2, st_s3, st_s4;
	logic signed [17:0]   opa_d, opa_s1;
	logic [14:0]          opb_d, opb_s1;
	logic signed [33:0]   prod_s2;
	logic signed [33:0]   rnd_sum;
	logic signed [33:0]   rnd_shift;
	lhods_pkg::step_t     st3_d;
	logic signed [32:0]   goal_sum;
	logic [30:0]          goal_new;
	lhods_pkg::step_t     st4_d;
	logic signed [31:0]   origin_s4;
	logic signed [32:0]   pos_sum;
	logic signed [31:0]   pos_sat;
	lhods_pkg::out_item_t out_d;
	logic                 out_valid_q;
	lhods_pkg::out_item_t out_q;

	// Lift state.
	logic [lhods_pkg::NUM_LIFTS-1:0][30:0] goal_q;
	logic [lhods_pkg::NUM_LIFTS-1:0][31:0] origin_q;

	// Operand selection helpers.
	logic [1:0]         idx;
	logic signed [17:0] f18, s18, t18;
	logic signed [17:0] mix [4];

	// The whole pipeline moves whenever the output register can take a beat.
	assign en        = !out_valid_q || out_ready;
	assign last_step = (job_q.kind == lhods_pkg::JOB_HOMING) ?
		(step_q == lhods_pkg::STEP_W'(lhods_pkg::HOMING_STEPS - 1)) :
		(step_q == lhods_pkg::STEP_W'(lhods_pkg::DRIVE_STEPS - 1));
	assign take      = en && (!busy_q || last_step);
	assign q_pop     = take && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (en) begin
			if (!busy_q || last_step) begin
				busy_q <= q_valid;
				step_q <= '0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_head;
		end
	end

	// Decode the current step into a command and multiplier operands.
	always_comb begin
		idx    = step_q[1:0];
		f18    = {{2{job_q.fwd[15]}}, job_q.fwd};
		s18    = {{2{job_q.side[15]}}, job_q.side};
		t18    = {{2{job_q.turn[15]}}, job_q.turn};
		mix[0] = f18 - s18 + t18;
		mix[1] = f18 + s18 - t18;
		mix[2] = -f18 + s18 + t18;
		mix[3] = -f18 - s18 - t18;

		st_d.idx         = idx;
		st_d.hit         = job_q.hit[idx];
		st_d.angle       = job_q.angle[idx];
		st_d.clear_goals = 1'b0;
		st_d.value       = '0;
		opa_d            = '0;
		opb_d            = '0;
		if (job_q.kind == lhods_pkg::JOB_HOMING) begin
			st_d.kind        = lhods_pkg::STEP_HOME;
			st_d.motor_num   = lhods_pkg::LIFT_ID_BASE + {2'b00, idx};
			st_d.mode        = lhods_pkg::CTRL_SPEED;
			st_d.last        = last_step;
			st_d.clear_goals = job_q.all_hit && last_step;
			st_d.value       = job_q.hit[idx] ? 32'sd0 :
				{{9{cfg.home_rpm[22]}}, cfg.home_rpm};
		end else if (!step_q[lhods_pkg::STEP_W-1]) begin
			st_d.kind      = lhods_pkg::STEP_WHEEL;
			st_d.motor_num = lhods_pkg::WHEEL_ID_BASE + {2'b00, idx};
			st_d.mode      = lhods_pkg::CTRL_SPEED;
			st_d.last      = 1'b0;
			opa_d          = mix[idx];
			opb_d          = cfg.max_wheel_rpm;
		end else begin
			st_d.kind      = lhods_pkg::STEP_LIFT;
			st_d.motor_num = lhods_pkg::LIFT_ID_BASE + {2'b00, idx};
			st_d.mode      = lhods_pkg::CTRL_POSITION;
			st_d.last      = last_step;
			opa_d          = {{2{job_q.lift[15]}}, job_q.lift};
			opb_d          = cfg.lift_step;
		end
	end

	// Rounding: add half, less one for negatives, then an arithmetic shift gives
	// round to nearest with ties away from zero.
	always_comb begin
		st3_d = st_s2;
		if (st_s2.kind == lhods_pkg::STEP_LIFT) begin
			rnd_sum   = prod_s2 + lhods_pkg::LIFT_HALF - {33'd0, prod_s2[33]};
			rnd_shift = rnd_sum >>> lhods_pkg::LIFT_SHIFT;
		end else begin
			rnd_sum   = prod_s2 + lhods_pkg::WHEEL_HALF - {33'd0, prod_s2[33]};
			rnd_shift = rnd_sum >>> lhods_pkg::WHEEL_SHIFT;
		end
		if (st_s2.kind != lhods_pkg::STEP_HOME) begin
			st3_d.value = rnd_shift[31:0];
		end
	end

	// Lift goal: integrate, clamp at zero and saturate high.
	always_comb begin
		goal_sum = $signed({2'b00, goal_q[st_s3.idx]}) +
			$signed({st_s3.value[31], st_s3.value});
		if (goal_sum[32]) begin
			goal_new = '0;
		end else if (goal_sum[31]) begin
			goal_new = '1;
		end else begin
			goal_new = goal_sum[30:0];
		end
		st4_d = st_s3;
		if (st_s3.kind == lhods_pkg::STEP_LIFT) begin
			st4_d.value = {1'b0, goal_new};
		end
	end

	// Position setpoint: goal plus origin, saturated to 32 bits.
	always_comb begin
		pos_sum = $signed({st_s4.value[31], st_s4.value}) + $signed({origin_s4[31], origin_s4});
		if (pos_sum[32] != pos_sum[31]) begin
			pos_sat = pos_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			pos_sat = pos_sum[31:0];
		end
		out_d.motor_num    = st_s4.motor_num;
		out_d.control_mode = st_s4.mode;
		out_d.last_command = st_s4.last;
		out_d.setpoint     = (st_s4.kind == lhods_pkg::STEP_LIFT) ? pos_sat : st_s4.value;
	end

	// Stage valids and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= busy_q;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (en) begin
			st_s1     <= st_d;
			opa_s1    <= opa_d;
			opb_s1    <= opb_d;
			st_s2     <= st_s1;
			prod_s2   <= opa_s1 * $signed({1'b0, opb_s1});
			st_s3     <= st3_d;
			st_s4     <= st4_d;
			origin_s4 <= origin_q[st_s3.idx];
			out_q     <= out_d;
		end
	end

	// Origins latch at end stop during homing; goals move on lift steps and
	// clear once every lift is homed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_q   <= '0;
			origin_q <= '0;
		end else if (en && v_s3) begin
			if (st_s3.kind == lhods_pkg::STEP_LIFT) begin
				goal_q[st_s3.idx] <= goal_new;
			end
			if ((st_s3.kind == lhods_pkg::STEP_HOME) && st_s3.hit) begin
				origin_q[st_s3.idx] <= st_s3.angle;
			end
			if ((st_s3.kind == lhods_pkg::STEP_HOME) && st_s3.clear_goals) begin
				goal_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_last_motor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.last_command |-> out_q.motor_num == lhods_pkg::LAST_MOTOR_NUM)
		else $error("final command of a tick is not for the last lift");

	a_goal_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && (st_s4.kind == lhods_pkg::STEP_LIFT) |-> !st_s4.value[31])
		else $error("lift goal went negative");

endmodule

FILE: hw/rtl/lift_homing_and_omni_drive_sequencer_core.sv
// Lift homing and omni drive sequencer, top level: configuration registers and the
// front end, job queue and back end. Throughput: one command per cycle unless the
// output stalls; a homing tick gives 4 commands, a drive tick 8 in a row.
// Input beats are taken every cycle while the two-entry job queue has room.
// Reset (arst_n low) clears state, phase, feedback, origins and goals, and loads
// the configuration defaults; there is no clearing pass.
module lift_homing_and_omni_drive_sequencer_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  lhods_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output lhods_pkg::out_item_t out_data,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [22:0]          cfg_data
);

	lhods_pkg::cfg_t cfg_q;
	logic            q_full;
	logic            q_push;
	lhods_pkg::job_t q_job;
	logic            q_pop;
	logic            q_valid;
	lhods_pkg::job_t q_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_rpm          <= lhods_pkg::HOME_RPM_RST;
			cfg_q.current_threshold <= lhods_pkg::THRESHOLD_RST;
			cfg_q.max_wheel_rpm     <= lhods_pkg::MAX_RPM_RST;
			cfg_q.lift_step         <= lhods_pkg::LIFT_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lhods_pkg::CFG_HOME_RPM:  cfg_q.home_rpm          <= cfg_data;
				lhods_pkg::CFG_THRESHOLD: cfg_q.current_threshold <= cfg_data[14:0];
				lhods_pkg::CFG_MAX_RPM:   cfg_q.max_wheel_rpm     <= cfg_data[14:0];
				lhods_pkg::CFG_LIFT_STEP: cfg_q.lift_step         <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	lhods_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_job)
	);

	lhods_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_job),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	lhods_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
